### sv/lbir_pkg.sv
// Shared types and constants of the bimodal-insertion LRU replacement unit.
`default_nettype none

package lbir_pkg;

  // Width of one last-use stamp and of the access clock.
  localparam int unsigned STAMP_W = 64;

  // A fill inserts at the most-recent position one time in this many.
  localparam int unsigned BIP_ODDS = 32;

  // Item modes.
  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_ACCESS = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

  // Work that an item needs once its set row has been read.
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_STAMP,
    OP_FILL_MIN
  } op_e;

endpackage

`default_nettype wire

### sv/lbir_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module lbir_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/lru_bimodal_insertion_replacement_unit.sv
// Bimodal-insertion LRU replacement unit: per-set way stamps kept in one row-wide RAM.
// A read hit or a fill that inserts at the most-recent position keeps busy_o high for
// the row read, with the write-back at its end; a victim query or a fill that copies the
// set minimum keeps it high for the row read and then one compare per remaining way, the
// scan over the row. Items that change nothing leave busy_o low. A victim result strobes
// the cycle after the scan. Reset: the stamp RAM is cleared one set row per cycle, with
// busy_o high.
`default_nettype none

module lru_bimodal_insertion_replacement_unit #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [5:0] set_index_i,
  input  wire logic [2:0] way_index_i,
  input  wire logic       was_hit_i,
  input  wire logic       is_write_i,
  input  wire logic [4:0] random_draw_i,
  output logic            result_valid_o,
  output logic      [2:0] victim_way_o
);

  localparam int unsigned SW    = lbir_pkg::STAMP_W;
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W = $clog2(WAYS);
  localparam int unsigned ROW_W = WAYS * SW;

  lbir_pkg::state_e state_q, state_d;
  lbir_pkg::op_e    op_q, op_d;

  logic [SET_W-1:0] set_q, set_d;
  logic [WAY_W-1:0] way_q, way_d;
  logic [WAY_W-1:0] best_q, best_d;
  logic [SW-1:0]    best_stamp_q, best_stamp_d;
  logic [WAY_W-1:0] idx_q, idx_d;
  logic [SET_W-1:0] clr_q, clr_d;
  logic [SW-1:0]    clock_q, clock_d;
  logic             res_valid_q, res_valid_d;
  logic [2:0]       res_way_q, res_way_d;

  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic             accept;
  logic             set_ok, way_ok, stamp_item, fill_min_item, query_item;
  logic             clr_last, scan_last;
  logic [SW-1:0]    cand;
  logic             less;
  logic [WAY_W-1:0] fin_best;
  logic [SW-1:0]    fin_stamp;
  logic [SW-1:0]    new_stamp;

  lbir_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Item decode at the port.
  assign busy_o = (state_q != lbir_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;
  assign set_ok = (32'(set_index_i) < SETS);
  assign way_ok = (32'(way_index_i) < WAYS);

  always_comb begin
    query_item    = (mode_i == lbir_pkg::MODE_QUERY) && set_ok;
    stamp_item    = 1'b0;
    fill_min_item = 1'b0;
    if (set_ok && way_ok) begin
      if (mode_i == lbir_pkg::MODE_FILL) begin
        // A zero draw inserts at the most-recent position.
        if ((32'(random_draw_i) % lbir_pkg::BIP_ODDS) == 32'd0) begin
          stamp_item = 1'b1;
        end else begin
          fill_min_item = 1'b1;
        end
      end else if (mode_i == lbir_pkg::MODE_ACCESS) begin
        stamp_item = was_hit_i && !is_write_i;
      end
    end
  end

  // One step of the minimum scan over the held row.
  assign cand      = ram_rdata[idx_q*SW +: SW];
  assign less      = (cand < best_stamp_q);
  assign fin_best  = less ? idx_q : best_q;
  assign fin_stamp = less ? cand : best_stamp_q;
  assign scan_last = (idx_q == WAY_W'(WAYS - 1));
  assign clr_last  = (clr_q == SET_W'(SETS - 1));

  // Stamp written back: the clock for a stamp item, the set minimum for a plain fill.
  assign new_stamp = (op_q == lbir_pkg::OP_STAMP) ? clock_q : fin_stamp;

  // Row with the addressed way replaced.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way_q) begin
        ram_wdata[w*SW +: SW] = new_stamp;
      end else begin
        ram_wdata[w*SW +: SW] = ram_rdata[w*SW +: SW];
      end
    end
    if (state_q == lbir_pkg::ST_CLEAR) begin
      ram_wdata = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbir_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = lbir_pkg::ST_IDLE;
        end
      end
      lbir_pkg::ST_IDLE: begin
        if (accept && (query_item || stamp_item || fill_min_item)) begin
          state_d = lbir_pkg::ST_READ;
        end
      end
      lbir_pkg::ST_READ: begin
        if (op_q == lbir_pkg::OP_STAMP) begin
          state_d = lbir_pkg::ST_IDLE;
        end else begin
          state_d = lbir_pkg::ST_SCAN;
        end
      end
      lbir_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = lbir_pkg::ST_IDLE;
        end
      end
      default: state_d = lbir_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    op_d         = op_q;
    set_d        = set_q;
    way_d        = way_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    idx_d        = idx_q;
    clr_d        = clr_q;
    clock_d      = clock_q;
    res_valid_d  = 1'b0;
    res_way_d    = res_way_q;
    ram_we       = 1'b0;
    ram_waddr    = set_q;
    ram_re       = 1'b0;
    ram_raddr    = SET_W'(set_index_i);
    case (state_q)
      lbir_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + SET_W'(1);
      end
      lbir_pkg::ST_IDLE: begin
        if (accept) begin
          set_d = SET_W'(set_index_i);
          way_d = WAY_W'(way_index_i);
          if (query_item) begin
            op_d = lbir_pkg::OP_QUERY;
          end else if (stamp_item) begin
            op_d = lbir_pkg::OP_STAMP;
          end else begin
            op_d = lbir_pkg::OP_FILL_MIN;
          end
          ram_re = query_item || stamp_item || fill_min_item;
          // A query of a set outside the cache answers way 0 at once.
          if ((mode_i == lbir_pkg::MODE_QUERY) && !set_ok) begin
            res_valid_d = 1'b1;
            res_way_d   = 3'd0;
          end
        end
      end
      lbir_pkg::ST_READ: begin
        if (op_q == lbir_pkg::OP_STAMP) begin
          ram_we  = 1'b1;
          clock_d = clock_q + SW'(1);
        end else begin
          best_d       = '0;
          best_stamp_d = ram_rdata[SW-1:0];
          idx_d        = WAY_W'(1);
        end
      end
      lbir_pkg::ST_SCAN: begin
        best_d       = fin_best;
        best_stamp_d = fin_stamp;
        idx_d        = idx_q + WAY_W'(1);
        if (scan_last) begin
          if (op_q == lbir_pkg::OP_QUERY) begin
            res_valid_d = 1'b1;
            res_way_d   = 3'(fin_best);
          end else begin
            ram_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbir_pkg::ST_CLEAR;
      clr_q       <= '0;
      clock_q     <= '0;
      res_valid_q <= 1'b0;
      op_q        <= lbir_pkg::OP_QUERY;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clock_q     <= clock_d;
      res_valid_q <= res_valid_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    set_q        <= set_d;
    way_q        <= way_d;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    res_way_q    <= res_way_d;
  end

  assign result_valid_o = res_valid_q;
  assign victim_way_o   = res_way_q;

  // The stamp RAM never sees a read and a write in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("stamp RAM read and write overlap");

  // The access clock advances by at most one per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clock_q == $past(clock_q)) || (clock_q == $past(clock_q) + SW'(1)))
    else $error("access clock jumped");

  // A result follows only a scan or an idle cycle, never the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == lbir_pkg::ST_SCAN ||
                        $past(state_q) == lbir_pkg::ST_IDLE))
    else $error("result outside a query");

  // The scan index stays within the ways.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbir_pkg::ST_SCAN) |-> (32'(idx_q) < WAYS))
    else $error("scan index out of range");

endmodule

`default_nettype wire
